FILE: hdl/dcid_pkg.sv
// ----------------------------------------------------------------------------
// dcid_pkg
// Shared types, codes and reset values of the dual contact input debouncer.
// ----------------------------------------------------------------------------
package dcid_pkg;

  localparam int DEFAULT_COUNT_WIDTH  = 16;
  localparam int DEFAULT_SAMPLE_WIDTH = 16;

  localparam int SAMPLE_FIELD_W = 16;
  localparam int CFG_DATA_W     = 16;
  localparam int CFG_INDEX_W    = 3;
  localparam int HOLD_W         = 16;

  typedef logic [1:0] class_t;
  typedef logic [1:0] mode_t;

  localparam class_t CLS_LOW   = 2'd0;
  localparam class_t CLS_HIGH  = 2'd1;
  localparam class_t CLS_UNDEF = 2'd2;

  localparam mode_t MODE_SINGLE   = 2'd0;
  localparam mode_t MODE_DUAL     = 2'd1;
  localparam mode_t MODE_DISABLED = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_INPUT_MODE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LOW_HOLD   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_HIGH_HOLD  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_UNDEF_HOLD = 3'd4;

  localparam mode_t               RST_INPUT_MODE = MODE_SINGLE;
  localparam logic [HOLD_W-1:0]   RST_THRESHOLD  = 16'd32768;
  localparam logic [HOLD_W-1:0]   RST_HOLD_TIME  = 16'd10;

  // Raw classification of one sample pair
  typedef struct packed {
    logic   active;  // mode processes samples
    class_t cls;
  } cls_info_t;

  // Result of one tick
  typedef struct packed {
    logic   level_changed;
    class_t level;
    class_t previous_level;
  } level_res_t;

endpackage

FILE: hdl/dcid_if.sv
// ----------------------------------------------------------------------------
// dcid channel interfaces
// Valid/ready channels for samples, results and register writes.
// ----------------------------------------------------------------------------
interface dcid_sample_if;
  import dcid_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [SAMPLE_FIELD_W-1:0] sample_a;
  logic [SAMPLE_FIELD_W-1:0] sample_b;
  modport source (output valid, sample_a, sample_b, input ready);
  modport sink   (input valid, sample_a, sample_b, output ready);
endinterface

interface dcid_level_if;
  import dcid_pkg::*;
  logic   valid;
  logic   ready;
  logic   level_changed;
  class_t level;
  class_t previous_level;
  modport source (output valid, level_changed, level, previous_level, input ready);
  modport sink   (input valid, level_changed, level, previous_level, output ready);
endinterface

interface dcid_cfg_if;
  import dcid_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/dcid_classify.sv
// ----------------------------------------------------------------------------
// dcid_classify
// Threshold compare of both contacts and raw class selection by mode.
// ----------------------------------------------------------------------------
module dcid_classify #(
  parameter int SAMPLE_WIDTH = dcid_pkg::DEFAULT_SAMPLE_WIDTH
) (
  input  logic [SAMPLE_WIDTH-1:0]     sample_a,
  input  logic [SAMPLE_WIDTH-1:0]     sample_b,
  input  logic [dcid_pkg::HOLD_W-1:0] threshold,
  input  dcid_pkg::mode_t             input_mode,
  output dcid_pkg::cls_info_t         info
);
  import dcid_pkg::*;

  logic up;
  logic lo;

  assign up = HOLD_W'(sample_a) > threshold;
  assign lo = HOLD_W'(sample_b) > threshold;

  always_comb begin
    info.active = 1'b0;
    info.cls    = CLS_LOW;
    unique case (input_mode)
      MODE_SINGLE: begin
        info.active = 1'b1;
        info.cls    = up ? CLS_HIGH : CLS_LOW;
      end
      MODE_DUAL: begin
        info.active = 1'b1;
        if (up && lo) begin
          info.cls = CLS_LOW;
        end else if (up) begin
          info.cls = CLS_HIGH;
        end else begin
          info.cls = CLS_UNDEF;
        end
      end
      default: begin
        info.active = 1'b0;
      end
    endcase
  end

endmodule

FILE: hdl/dcid_track.sv
// ----------------------------------------------------------------------------
// dcid_track
// Hold counter and debounced level state; updated once per advanced item.
// ----------------------------------------------------------------------------
module dcid_track #(
  parameter int COUNT_WIDTH = dcid_pkg::DEFAULT_COUNT_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        advance,
  input  dcid_pkg::cls_info_t         info,
  input  logic [dcid_pkg::HOLD_W-1:0] low_hold_time,
  input  logic [dcid_pkg::HOLD_W-1:0] high_hold_time,
  input  logic [dcid_pkg::HOLD_W-1:0] undefined_hold_time,
  output dcid_pkg::level_res_t        res
);
  import dcid_pkg::*;

  localparam int CMP_W = (COUNT_WIDTH > HOLD_W) ? COUNT_WIDTH : HOLD_W;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  logic                   started, started_next;
  class_t                 last_class, last_class_next;
  logic [COUNT_WIDTH-1:0] hold_count, hold_count_next;
  class_t                 current_level, current_level_next;
  class_t                 prior_level, prior_level_next;

  logic [COUNT_WIDTH-1:0] count_base;
  logic [HOLD_W-1:0]      hold;

  always_comb begin
    started_next       = started;
    last_class_next    = last_class;
    hold_count_next    = hold_count;
    current_level_next = current_level;
    prior_level_next   = prior_level;
    res.level_changed  = 1'b0;

    count_base = (last_class != info.cls) ? '0 : hold_count;
    unique case (info.cls)
      CLS_LOW:  hold = low_hold_time;
      CLS_HIGH: hold = high_hold_time;
      default:  hold = undefined_hold_time;
    endcase

    if (info.active) begin
      if (!started) begin
        // first tick loads the level quietly, counter untouched
        started_next       = 1'b1;
        last_class_next    = info.cls;
        current_level_next = info.cls;
        prior_level_next   = info.cls;
      end else begin
        last_class_next = info.cls;
        // zero-extend both so an out-of-range hold time never matches
        if (CMP_W'(count_base) == CMP_W'(hold)) begin
          prior_level_next   = current_level;
          current_level_next = info.cls;
          res.level_changed  = 1'b1;
        end
        hold_count_next = (count_base == COUNT_MAX) ? count_base : count_base + 1'b1;
      end
    end

    res.level          = current_level_next;
    res.previous_level = prior_level_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started       <= 1'b0;
      last_class    <= CLS_LOW;
      hold_count    <= '0;
      current_level <= CLS_LOW;
      prior_level   <= CLS_LOW;
    end else if (advance) begin
      started       <= started_next;
      last_class    <= last_class_next;
      hold_count    <= hold_count_next;
      current_level <= current_level_next;
      prior_level   <= prior_level_next;
    end
  end

endmodule

FILE: hdl/dual_contact_input_debouncer_unit.sv
// ----------------------------------------------------------------------------
// dual_contact_input_debouncer_unit
// Threshold classifier and hold-time debouncer for one or two contacts.
// ----------------------------------------------------------------------------
// One sample pair is taken per cycle unless the result side stalls, and each
// transfer yields exactly one result: the pair is captured in the input
// register, then classification, hold counting and the level update settle
// in one pass and land in the result register. Throughput is one item per
// clock unless the receiver holds off; the input side keeps accepting while
// a result waits as long as the output register frees up in the same cycle.
// Registers (input mode, threshold, three hold times) are written through the
// config channel, which is always ready, and must only change while idle.
module dual_contact_input_debouncer_unit #(
  parameter int COUNT_WIDTH  = dcid_pkg::DEFAULT_COUNT_WIDTH,
  parameter int SAMPLE_WIDTH = dcid_pkg::DEFAULT_SAMPLE_WIDTH
) (
  input  logic          clk,
  input  logic          rst,
  dcid_cfg_if.sink      cfg,
  dcid_sample_if.sink   samples,
  dcid_level_if.source  levels
);
  import dcid_pkg::*;

  mode_t             input_mode;
  logic [HOLD_W-1:0] threshold;
  logic [HOLD_W-1:0] low_hold_time;
  logic [HOLD_W-1:0] high_hold_time;
  logic [HOLD_W-1:0] undefined_hold_time;

  logic                    s1_valid;
  logic [SAMPLE_WIDTH-1:0] s1_a;
  logic [SAMPLE_WIDTH-1:0] s1_b;
  logic                    out_valid;
  level_res_t              out_res;

  logic       advance;
  cls_info_t  info;
  level_res_t res;

  // config registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      input_mode          <= RST_INPUT_MODE;
      threshold           <= RST_THRESHOLD;
      low_hold_time       <= RST_HOLD_TIME;
      high_hold_time      <= RST_HOLD_TIME;
      undefined_hold_time <= RST_HOLD_TIME;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_INPUT_MODE: input_mode          <= cfg.data[1:0];
        REG_THRESHOLD:  threshold           <= cfg.data;
        REG_LOW_HOLD:   low_hold_time       <= cfg.data;
        REG_HIGH_HOLD:  high_hold_time      <= cfg.data;
        REG_UNDEF_HOLD: undefined_hold_time <= cfg.data;
        default: ;
      endcase
    end
  end

  // pipeline control
  assign advance       = s1_valid && (!out_valid || levels.ready);
  assign samples.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (samples.ready) begin
      s1_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      s1_a <= samples.sample_a[SAMPLE_WIDTH-1:0];
      s1_b <= samples.sample_b[SAMPLE_WIDTH-1:0];
    end
  end

  dcid_classify #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_classify (
    .sample_a   (s1_a),
    .sample_b   (s1_b),
    .threshold  (threshold),
    .input_mode (input_mode),
    .info       (info)
  );

  dcid_track #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_track (
    .clk                 (clk),
    .rst                 (rst),
    .advance             (advance),
    .info                (info),
    .low_hold_time       (low_hold_time),
    .high_hold_time      (high_hold_time),
    .undefined_hold_time (undefined_hold_time),
    .res                 (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (levels.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign levels.valid          = out_valid;
  assign levels.level_changed  = out_res.level_changed;
  assign levels.level          = out_res.level;
  assign levels.previous_level = out_res.previous_level;

  // checks
  a_level_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_res.level != 2'd3 && out_res.previous_level != 2'd3))
    else $error("debounced level carries an unused code");

  a_advance_fills_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("advanced item did not reach the result register");

  a_stage_held: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> s1_valid)
    else $error("stalled input item dropped");

  a_quiet_when_off: assert property (@(posedge clk) disable iff (rst)
    (advance && !info.active) |=> !out_res.level_changed)
    else $error("level change reported in a disabled mode");

endmodule

FILE: dv/dcid_level_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcid_level_checker
// Watches the register, sample and level channels of the debouncer. Keeps
// its own copy of the registers and the debounce state, predicts one level
// result per sample transfer and compares every result transfer against the
// oldest prediction, field by field.
// ----------------------------------------------------------------------------
module dcid_level_checker (
  input  logic   clk,
  input  logic   rst,
  dcid_cfg_if    cfg,
  dcid_sample_if samples,
  dcid_level_if  levels,
  output int     fail_count,
  output int     pending_count
);
  import dcid_pkg::*;

  localparam logic [DEFAULT_COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // register shadow
  mode_t             mode;
  logic [HOLD_W-1:0] thresh;
  logic [HOLD_W-1:0] hold_low;
  logic [HOLD_W-1:0] hold_high;
  logic [HOLD_W-1:0] hold_undef;

  // debounce state
  logic                           started;
  class_t                         last_cls;
  logic [DEFAULT_COUNT_WIDTH-1:0] hold_cnt;
  class_t                         cur_level;
  class_t                         prior_level;

  level_res_t expected_levels[$];
  int         mismatches = 0;
  int         results_seen = 0;

  assign fail_count = mismatches;

  task automatic report_mismatch(input string what, input int got_v, input int want_v);
    $display("MISMATCH result %0d %s: got %0d expected %0d", results_seen, what, got_v,
             want_v);
    mismatches++;
  endtask

  // Advances the debounce state by one sample pair (single and dual mode only) and returns the level result.
  function automatic level_res_t debounce_step(input logic [SAMPLE_FIELD_W-1:0] a,
                                               input logic [SAMPLE_FIELD_W-1:0] b);
    level_res_t        res;
    logic              up_on;
    logic              lo_on;
    class_t            cls;
    logic [HOLD_W-1:0] need;
    up_on = a > thresh;
    lo_on = b > thresh;
    res.level_changed = 1'b0;
    if (mode == MODE_SINGLE || mode == MODE_DUAL) begin
      if (mode == MODE_SINGLE) begin
        cls = up_on ? CLS_HIGH : CLS_LOW;
      end else if (up_on && lo_on) begin
        cls = CLS_LOW;
      end else if (up_on) begin
        cls = CLS_HIGH;
      end else begin
        cls = CLS_UNDEF;
      end
      if (!started) begin
        // first processed pair loads the level, counter untouched
        started     = 1'b1;
        last_cls    = cls;
        cur_level   = cls;
        prior_level = cls;
      end else begin
        if (last_cls != cls) begin
          hold_cnt = '0;
          last_cls = cls;
        end
        case (cls)
          CLS_LOW:  need = hold_low;
          CLS_HIGH: need = hold_high;
          default:  need = hold_undef;
        endcase
        if (hold_cnt == need) begin
          prior_level       = cur_level;
          cur_level         = cls;
          res.level_changed = 1'b1;
        end
        if (hold_cnt != COUNT_MAX) begin
          hold_cnt = hold_cnt + 1'b1;
        end
      end
    end
    res.level          = cur_level;
    res.previous_level = prior_level;
    return res;
  endfunction

  always @(posedge clk) begin
    level_res_t got;
    level_res_t want;
    if (rst) begin
      mode        = RST_INPUT_MODE;
      thresh      = RST_THRESHOLD;
      hold_low    = RST_HOLD_TIME;
      hold_high   = RST_HOLD_TIME;
      hold_undef  = RST_HOLD_TIME;
      started     = 1'b0;
      last_cls    = CLS_LOW;
      hold_cnt    = '0;
      cur_level   = CLS_LOW;
      prior_level = CLS_LOW;
      expected_levels.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_INPUT_MODE: mode       = cfg.data[1:0];
          REG_THRESHOLD:  thresh     = cfg.data;
          REG_LOW_HOLD:   hold_low   = cfg.data;
          REG_HIGH_HOLD:  hold_high  = cfg.data;
          REG_UNDEF_HOLD: hold_undef = cfg.data;
          default: ;
        endcase
      end
      if (samples.valid && samples.ready) begin
        expected_levels.push_back(debounce_step(samples.sample_a, samples.sample_b));
      end
      if (levels.valid && levels.ready) begin
        got.level_changed  = levels.level_changed;
        got.level          = levels.level;
        got.previous_level = levels.previous_level;
        if (expected_levels.size() == 0) begin
          report_mismatch("transfer with nothing expected", got, 0);
        end else begin
          want = expected_levels.pop_front();
          if (got.level_changed !== want.level_changed)
            report_mismatch("level_changed", got.level_changed, want.level_changed);
          if (got.level !== want.level)
            report_mismatch("level", got.level, want.level);
          if (got.previous_level !== want.previous_level)
            report_mismatch("previous_level", got.previous_level, want.previous_level);
        end
        results_seen++;
      end
    end
    pending_count <= expected_levels.size();
  end

endmodule

FILE: dv/dual_contact_input_debouncer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_contact_input_debouncer_unit_tb
// Drives register writes and sample pairs into the debouncer and lets the
// level checker judge every result. A short directed part covers the
// disabled and unknown modes, the first processed pair, threshold edges and
// zero hold times; random phases then feed runs of one class with random
// sample values under changing settings and idle patterns, and a final
// back-to-back stream holds one class past its hold time.
// ----------------------------------------------------------------------------
module dual_contact_input_debouncer_unit_tb;
  import dcid_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 3'd5;
  localparam mode_t MODE_UNKNOWN = 2'd3;
  localparam int CYCLE_LIMIT   = 50000;
  localparam int PHASE_ITEMS   = 115;
  localparam int STEADY_ITEMS  = 20;
  localparam int STALL_CYCLES  = 300;
  localparam int DRAIN_CYCLES  = 8;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending_count;
  int   cycle_cnt = 0;

  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int stall_req = 0;
  int stall_ack = 0;
  int stall_left = 0;

  // shadow of the written registers, used only to shape stimulus
  mode_t                     cur_mode;
  logic [HOLD_W-1:0]         cur_thresh;
  logic [HOLD_W-1:0]         cur_hold[4];

  dcid_cfg_if    cfg_ch();
  dcid_sample_if smp_ch();
  dcid_level_if  lvl_ch();

  dual_contact_input_debouncer_unit dut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch),
    .samples (smp_ch),
    .levels  (lvl_ch)
  );

  dcid_level_checker chk (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg_ch),
    .samples       (smp_ch),
    .levels        (lvl_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: random idling plus an occasional long hold-off
  always @(posedge clk) begin
    if (stall_req != stall_ack) begin
      stall_ack    <= stall_req;
      stall_left   <= STALL_CYCLES;
      lvl_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      lvl_ch.ready <= 1'b0;
    end else begin
      lvl_ch.ready <= ($urandom_range(99, 0) >= snk_idle_pct);
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    cfg_ch.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_INPUT_MODE: cur_mode       = data[1:0];
      REG_THRESHOLD:  cur_thresh     = data;
      REG_LOW_HOLD:   cur_hold[CLS_LOW]   = data;
      REG_HIGH_HOLD:  cur_hold[CLS_HIGH]  = data;
      REG_UNDEF_HOLD: cur_hold[CLS_UNDEF] = data;
      default: ;
    endcase
  endtask

  // mode lives in the low bits; upper data bits get random junk
  task automatic set_mode(input mode_t m);
    logic [CFG_DATA_W-1:0] data;
    data = (16'($urandom) & 16'hFFFC) | 16'(m);
    write_reg(REG_INPUT_MODE, data);
  endtask

  task automatic configure(input mode_t m, input logic [HOLD_W-1:0] th,
                           input logic [HOLD_W-1:0] h_low, input logic [HOLD_W-1:0] h_high,
                           input logic [HOLD_W-1:0] h_undef);
    set_mode(m);
    write_reg(REG_THRESHOLD, th);
    write_reg(REG_LOW_HOLD, h_low);
    write_reg(REG_HIGH_HOLD, h_high);
    write_reg(REG_UNDEF_HOLD, h_undef);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_pair(input logic [SAMPLE_FIELD_W-1:0] a,
                           input logic [SAMPLE_FIELD_W-1:0] b);
    while ($urandom_range(99, 0) < src_idle_pct) begin
      smp_ch.valid <= 1'b0;
      @(posedge clk);
    end
    smp_ch.sample_a <= a;
    smp_ch.sample_b <= b;
    smp_ch.valid    <= 1'b1;
    @(posedge clk);
    while (!smp_ch.ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    smp_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  // idle point for register writes: everything back plus pipeline margin
  task automatic settle();
    wait_drained();
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [SAMPLE_FIELD_W-1:0] above_thresh();
    if (cur_thresh == 16'hFFFF) return 16'hFFFF;
    return 16'($urandom_range(16'hFFFF, cur_thresh + 1));
  endfunction

  function automatic logic [SAMPLE_FIELD_W-1:0] below_thresh();
    return 16'($urandom_range(cur_thresh, 0));
  endfunction

  function automatic logic [HOLD_W-1:0] pick_hold();
    if ($urandom_range(99, 0) < 75) return 16'($urandom_range(6, 0));
    return 16'($urandom_range(16'hFFFF, 7));
  endfunction

  task automatic send_class(input class_t cls);
    logic [SAMPLE_FIELD_W-1:0] a;
    logic [SAMPLE_FIELD_W-1:0] b;
    a = 16'($urandom);
    b = 16'($urandom);
    if (cur_mode == MODE_SINGLE) begin
      a = (cls == CLS_HIGH) ? above_thresh() : below_thresh();
    end else if (cur_mode == MODE_DUAL) begin
      case (cls)
        CLS_LOW: begin
          a = above_thresh();
          b = above_thresh();
        end
        CLS_HIGH: begin
          a = above_thresh();
          b = below_thresh();
        end
        default: a = below_thresh();
      endcase
    end
    send_pair(a, b);
  endtask

  // runs of one class of random length (at most the hold time plus three, never over 12), with some noise
  task automatic random_phase(input int n, input bit pause_mid);
    int     done;
    int     run;
    int     i;
    class_t cls;
    done = 0;
    while (done < n) begin
      cls = (cur_mode == MODE_SINGLE) ? class_t'($urandom_range(1, 0))
                                      : class_t'($urandom_range(2, 0));
      run = $urandom_range(1, (cur_hold[cls] > 9) ? 12 : cur_hold[cls] + 3);
      for (i = 0; i < run && done < n; i++) begin
        if ($urandom_range(99, 0) < 12) begin
          send_pair(16'($urandom), 16'($urandom));
        end else begin
          send_class(cls);
        end
        done++;
        if (pause_mid && done == n / 2) wait_drained();
      end
    end
  endtask

  initial begin
    int ph;
    int i;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= REG_INPUT_MODE;
    cfg_ch.data     <= '0;
    smp_ch.valid    <= 1'b0;
    smp_ch.sample_a <= '0;
    smp_ch.sample_b <= '0;
    rst             <= 1'b1;
    cur_mode   = RST_INPUT_MODE;
    cur_thresh = RST_THRESHOLD;
    for (i = 0; i < 4; i++) cur_hold[i] = RST_HOLD_TIME;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: disabled before any processing, then first pair on reset settings
    src_idle_pct = 18;
    snk_idle_pct = 80;
    write_reg(REG_SPARE, 16'($urandom));
    set_mode(MODE_DISABLED);
    cfg_ch.valid <= 1'b0;
    send_pair(16'hFFFF, 16'hFFFF);
    send_pair(16'h0000, 16'hFFFF);
    settle();
    set_mode(MODE_SINGLE);
    cfg_ch.valid <= 1'b0;
    send_pair(16'd32769, 16'h0000);
    send_pair(16'd32768, 16'h0000);
    send_pair(16'h0000, 16'hFFFF);
    send_pair(16'hFFFF, 16'h0000);
    // hold times of zero and one in dual mode
    settle();
    configure(MODE_DUAL, 16'd100, 16'd0, 16'd1, 16'd0);
    send_pair(16'd101, 16'd101);
    send_pair(16'd100, 16'd0);
    send_pair(16'hFFFF, 16'd5);
    send_pair(16'hFFFF, 16'd5);
    send_pair(16'hFFFF, 16'd101);
    send_pair(16'd0, 16'd0);
    send_pair(16'd32768, 16'd100);
    settle();
    set_mode(MODE_UNKNOWN);
    cfg_ch.valid <= 1'b0;
    send_pair(16'hFFFF, 16'hFFFF);
    send_pair(16'h0000, 16'h0000);

    for (ph = 0; ph < 7; ph++) begin
      src_idle_pct = (ph < 3) ? 18 : (ph < 5) ? 80 : 0;
      snk_idle_pct = (ph < 3) ? 80 : (ph < 5) ? 18 : 0;
      settle();
      case (ph)
        0: configure(MODE_SINGLE, RST_THRESHOLD, pick_hold(), pick_hold(), pick_hold());
        1: configure(MODE_DUAL, 16'h0000, pick_hold(), pick_hold(), pick_hold());
        2: configure(MODE_DUAL, 16'hFFFF, pick_hold(), pick_hold(), pick_hold());
        3: configure(MODE_SINGLE, 16'($urandom), pick_hold(), pick_hold(), pick_hold());
        5: configure($urandom_range(1, 0) ? MODE_DISABLED : MODE_UNKNOWN, 16'($urandom),
                     pick_hold(), pick_hold(), pick_hold());
        default: configure(MODE_DUAL, 16'($urandom), pick_hold(), pick_hold(), pick_hold());
      endcase
      // receiver holds off while the sender keeps offering
      if (ph == 4) stall_req <= stall_req + 1;
      random_phase((ph == 5) ? 40 : PHASE_ITEMS, ph == 1);
    end

    // steady back-to-back low run that outlasts its hold time
    src_idle_pct = 0;
    snk_idle_pct = 0;
    settle();
    configure(MODE_SINGLE, 16'd1000, 16'd12, 16'd0, 16'd0);
    for (i = 0; i < STEADY_ITEMS; i++) send_pair(below_thresh(), 16'($urandom));

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/dcid_pkg.sv
hdl/dcid_if.sv
hdl/dcid_classify.sv
hdl/dcid_track.sv
hdl/dual_contact_input_debouncer_unit.sv
dv/dcid_level_checker.sv
dv/dual_contact_input_debouncer_unit_tb.sv
